// ===== rtl/sgtr_pkg.sv =====
// Shared types, constants and the 5x7 font table for the scaled glyph text rasterizer.
// Used by sgtr_col_mask and scaled_glyph_text_rasterizer; no dependencies.
package sgtr_pkg;

  localparam int FRAME_COLUMNS_DEF = 128;
  localparam int FRAME_PAGES_DEF   = 8;
  localparam int GLYPH_COLS        = 5;
  localparam int GLYPH_ROWS        = 7;
  localparam int PAGE_ROWS         = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_NEW   = 2'd1,
    OP_CONT  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Entry 0 is the leftmost column, bit 0 the top row.
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic   missing;
    glyph_t cols;
  } glyph_lookup_t;

  // Vertical walk position inside a scaled glyph column.
  typedef struct packed {
    logic [2:0] row;
    logic [3:0] sy;
  } rowpos_t;

  function automatic glyph_t g5(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                logic [7:0] d, logic [7:0] e);
    glyph_t g;
    g[0] = a[6:0];
    g[1] = b[6:0];
    g[2] = c[6:0];
    g[3] = d[6:0];
    g[4] = e[6:0];
    return g;
  endfunction

  function automatic glyph_lookup_t font_lookup(logic [7:0] code);
    glyph_lookup_t r;
    r.missing = 1'b0;
    case (code)
      8'h20: r.cols = g5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h30: r.cols = g5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: r.cols = g5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: r.cols = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: r.cols = g5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: r.cols = g5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: r.cols = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: r.cols = g5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: r.cols = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: r.cols = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: r.cols = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h2E: r.cols = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h2D: r.cols = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h3A: r.cols = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h25: r.cols = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      8'h43: r.cols = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h45: r.cols = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h48: r.cols = g5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: r.cols = g5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4C: r.cols = g5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: r.cols = g5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4F: r.cols = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: r.cols = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h52: r.cols = g5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: r.cols = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: r.cols = g5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: r.cols = g5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      8'h58: r.cols = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      8'hB0: r.cols = g5(8'h00, 8'h07, 8'h05, 8'h07, 8'h00);
      default: begin
        // unknown code: solid block
        r.missing = 1'b1;
        r.cols    = g5(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sgtr_col_mask.sv =====
// Builds the OR mask of one frame byte for one scaled glyph column and
// advances the vertical walk position by one page. Depends on sgtr_pkg.
module sgtr_col_mask (
  input  logic [6:0]       bits_i,
  input  logic [3:0]       scale_i,
  input  sgtr_pkg::rowpos_t pos_i,
  output logic [7:0]       mask_o,
  output sgtr_pkg::rowpos_t pos_o
);
  import sgtr_pkg::*;

  rowpos_t    pos;
  logic [7:0] mask;

  always_comb begin
    pos  = pos_i;
    mask = '0;
    for (int b = 0; b < PAGE_ROWS; b++) begin
      if (pos.row < 3'(GLYPH_ROWS)) begin
        mask[b] = bits_i[pos.row];
        // each glyph row repeats scale times
        if (pos.sy + 4'd1 == scale_i) begin
          pos.sy  = '0;
          pos.row = pos.row + 3'd1;
        end else begin
          pos.sy = pos.sy + 4'd1;
        end
      end
    end
  end

  assign mask_o = mask;
  assign pos_o  = pos;

endmodule

// ===== rtl/scaled_glyph_text_rasterizer.sv =====
// Top level: command sequencer, page-organized frame store and output register.
// Depends on sgtr_pkg and sgtr_col_mask.

// Draws 5x7 glyphs, magnified by an integer scale, into a frame store of
// FRAME_PAGES pages by FRAME_COLUMNS byte columns (bit 0 is the top pixel) and
// returns one result beat per command. One item is worked at a time; the store
// has a single read-modify-write path and every drawn byte goes through it.
// A draw visits up to 5*scale pixel columns and, on every page a non-empty
// column touches (about ceil(7*scale/8) pages, clipped to the store), reads
// the byte and writes it back merged with the glyph mask. Columns past the
// right edge end the glyph early. A read returns one stored byte, or zero
// outside the store; a continue on a stopped string draws nothing. Clear
// writes zero to every byte in turn, bypassing the read-modify-write path;
// the same pass runs after reset, and no input beat is taken until it is done.
module scaled_glyph_text_rasterizer #(
  parameter int FRAME_COLUMNS = sgtr_pkg::FRAME_COLUMNS_DEF,
  parameter int FRAME_PAGES   = sgtr_pkg::FRAME_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] start_column_i,
  input  logic [3:0] start_page_i,
  input  logic [3:0] scale_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [7:0] cursor_column_o,
  output logic       string_ended_o,
  output logic       glyph_missing_o
);
  import sgtr_pkg::*;

  localparam int DEPTH = FRAME_PAGES * FRAME_COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RD,
    S_COL,
    S_PG_RD,
    S_PG_WR,
    S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          sweep_op_q, sweep_op_d;
  logic [7:0]    cursor_q, cursor_d;
  logic [3:0]    spage_q, spage_d;
  logic [3:0]    scale_q, scale_d;
  logic          stopped_q, stopped_d;
  logic          missing_q, missing_d;
  logic [7:0]    fbyte_q, fbyte_d;
  logic          rd_hit_q, rd_hit_d;
  glyph_t        glyph_q, glyph_d;
  logic [2:0]    c_q, c_d;
  logic [3:0]    sx_q, sx_d;
  logic [8:0]    px_q, px_d;
  logic [4:0]    page_q, page_d;
  rowpos_t       pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    frame_byte_q, frame_byte_d;
  logic [7:0]    cursor_out_q, cursor_out_d;
  logic          ended_q, ended_d;
  logic          gmiss_q, gmiss_d;

  // frame store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  glyph_lookup_t lookup;
  logic [7:0]    new_cursor;
  logic [7:0]    cursor_adv;
  logic [6:0]    col_bits;
  logic [7:0]    mask;
  rowpos_t       pos_next;
  logic          col_last;
  logic [3:0]    sx_step;
  logic [2:0]    c_step;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;

  assign lookup     = font_lookup(char_code_i);
  assign new_cursor = (op_e'(operation_i) == OP_NEW) ? start_column_i : cursor_q;
  assign cursor_adv = cursor_q + 8'({4'b0, scale_q} * 8'd6);
  assign col_bits   = (c_q < 3'(GLYPH_COLS)) ? glyph_q[c_q] : '0;
  assign col_last   = (sx_q + 4'd1 == scale_q);
  assign sx_step    = col_last ? 4'd0 : sx_q + 4'd1;
  assign c_step     = col_last ? c_q + 3'd1 : c_q;
  assign draw_addr  = AW'(32'(page_q) * 32'(FRAME_COLUMNS) + 32'(px_q));
  assign rd_addr    = AW'(32'(read_page_i) * 32'(FRAME_COLUMNS) + 32'(read_column_i));
  assign rd_hit     = (5'(read_page_i) < 5'(FRAME_PAGES))
                   && (9'(read_column_i) < 9'(FRAME_COLUMNS));

  sgtr_col_mask u_col_mask (
    .bits_i  (col_bits),
    .scale_i (scale_q),
    .pos_i   (pos_q),
    .mask_o  (mask),
    .pos_o   (pos_next)
  );

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    sweep_op_d   = sweep_op_q;
    cursor_d     = cursor_q;
    spage_d      = spage_q;
    scale_d      = scale_q;
    stopped_d    = stopped_q;
    missing_d    = missing_q;
    fbyte_d      = fbyte_q;
    rd_hit_d     = rd_hit_q;
    glyph_d      = glyph_q;
    c_d          = c_q;
    sx_d         = sx_q;
    px_d         = px_q;
    page_d       = page_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q;
    frame_byte_d = frame_byte_q;
    cursor_out_d = cursor_out_q;
    ended_d      = ended_q;
    gmiss_d      = gmiss_q;
    mem_we       = 1'b0;
    mem_waddr    = draw_addr;
    mem_wdata    = mem_rdata_q | mask;
    mem_re       = 1'b0;
    mem_raddr    = draw_addr;

    // drop the result beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        if (sweep_q == AW'(DEPTH - 1)) begin
          sweep_d = '0;
          state_d = sweep_op_q ? S_FIN : S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          missing_d = 1'b0;
          fbyte_d   = '0;
          unique case (op_e'(operation_i)) inside
            OP_CLEAR: begin
              sweep_op_d = 1'b1;
              state_d    = S_SWEEP;
            end
            OP_READ: begin
              mem_re    = rd_hit;
              mem_raddr = rd_addr;
              rd_hit_d  = rd_hit;
              state_d   = S_RD;
            end
            OP_NEW, OP_CONT: begin
              if (op_e'(operation_i) == OP_NEW) begin
                cursor_d  = start_column_i;
                spage_d   = start_page_i;
                scale_d   = (scale_i == 4'd0) ? 4'd1 : scale_i;
                stopped_d = 1'b0;
              end
              if (op_e'(operation_i) == OP_NEW || !stopped_q) begin
                glyph_d   = lookup.cols;
                missing_d = lookup.missing;
                px_d      = {1'b0, new_cursor};
                c_d       = '0;
                sx_d      = '0;
                state_d   = S_COL;
              end else begin
                state_d = S_FIN;
              end
            end
          endcase
        end
      end
      S_RD: begin
        fbyte_d = rd_hit_q ? mem_rdata_q : 8'd0;
        state_d = S_FIN;
      end
      S_COL: begin
        if (c_q == 3'(GLYPH_COLS) || px_q >= 9'(FRAME_COLUMNS)) begin
          // glyph done or clipped on the right: advance the cursor
          cursor_d  = cursor_adv;
          stopped_d = {1'b0, cursor_adv} >= 9'(FRAME_COLUMNS);
          state_d   = S_FIN;
        end else if ({1'b0, spage_q} >= 5'(FRAME_PAGES) || col_bits == 7'd0) begin
          sx_d = sx_step;
          c_d  = c_step;
          px_d = px_q + 9'd1;
        end else begin
          page_d  = {1'b0, spage_q};
          pos_d   = '0;
          state_d = S_PG_RD;
        end
      end
      S_PG_RD: begin
        mem_re  = 1'b1;
        state_d = S_PG_WR;
      end
      S_PG_WR: begin
        mem_we = 1'b1;
        pos_d  = pos_next;
        page_d = page_q + 5'd1;
        if (pos_next.row == 3'(GLYPH_ROWS) || page_q + 5'd1 >= 5'(FRAME_PAGES)) begin
          sx_d    = sx_step;
          c_d     = c_step;
          px_d    = px_q + 9'd1;
          state_d = S_COL;
        end else begin
          state_d = S_PG_RD;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          frame_byte_d = fbyte_q;
          cursor_out_d = cursor_q;
          ended_d      = stopped_q;
          gmiss_d      = missing_q;
          sweep_op_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_q      <= '0;
      sweep_op_q   <= 1'b0;
      cursor_q     <= '0;
      spage_q      <= '0;
      scale_q      <= 4'd1;
      stopped_q    <= 1'b1;
      missing_q    <= 1'b0;
      fbyte_q      <= '0;
      rd_hit_q     <= 1'b0;
      glyph_q      <= '0;
      c_q          <= '0;
      sx_q         <= '0;
      px_q         <= '0;
      page_q       <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      frame_byte_q <= '0;
      cursor_out_q <= '0;
      ended_q      <= 1'b0;
      gmiss_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      sweep_op_q   <= sweep_op_d;
      cursor_q     <= cursor_d;
      spage_q      <= spage_d;
      scale_q      <= scale_d;
      stopped_q    <= stopped_d;
      missing_q    <= missing_d;
      fbyte_q      <= fbyte_d;
      rd_hit_q     <= rd_hit_d;
      glyph_q      <= glyph_d;
      c_q          <= c_d;
      sx_q         <= sx_d;
      px_q         <= px_d;
      page_q       <= page_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      frame_byte_q <= frame_byte_d;
      cursor_out_q <= cursor_out_d;
      ended_q      <= ended_d;
      gmiss_q      <= gmiss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = frame_byte_q;
  assign cursor_column_o = cursor_out_q;
  assign string_ended_o  = ended_q;
  assign glyph_missing_o = gmiss_q;

endmodule

// ===== test/scaled_glyph_text_rasterizer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scaled_glyph_text_rasterizer: directed table, then random strings and commands.
// Depends on sgtr_pkg and the rasterizer RTL; checks every result beat against a typed row or a local frame model.

module scaled_glyph_text_rasterizer_tb;
  import sgtr_pkg::*;

  localparam int RANDOM_ITEMS = 880;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    op_e        op;
    logic [7:0] code;
    logic [7:0] start_column;
    logic [3:0] start_page;
    logic [3:0] scale;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } raster_cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] cursor_column;
    logic       string_ended;
    logic       glyph_missing;
  } raster_beat_t;

  typedef struct packed {
    raster_cmd_t  cmd;
    logic         typed;
    raster_beat_t want;
  } script_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] operation_i = '0;
  logic [7:0] char_code_i = '0;
  logic [7:0] start_column_i = '0;
  logic [3:0] start_page_i = '0;
  logic [3:0] scale_i = '0;
  logic [2:0] read_page_i = '0;
  logic [6:0] read_column_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic [7:0] cursor_column_o;
  logic       string_ended_o;
  logic       glyph_missing_o;

  // Model of the block state
  logic [7:0] frame_model [FRAME_PAGES_DEF][FRAME_COLUMNS_DEF];
  logic [7:0] str_cursor = '0;
  logic [3:0] str_page = '0;
  int         str_scale = 1;
  logic       str_stopped = 1'b1;

  raster_beat_t expected_beats[$];
  script_row_t  script[$];
  int           fault_count = 0;
  int           beat_index = 0;
  int           accepted_count = 0;
  int           send_quiet = 0;
  int           sink_span = 0;
  int           sink_pick;
  logic         sink_busy = 1'b0;
  logic         hold_output = 1'b0;

  scaled_glyph_text_rasterizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .char_code_i    (char_code_i),
    .start_column_i (start_column_i),
    .start_page_i   (start_page_i),
    .scale_i        (scale_i),
    .read_page_i    (read_page_i),
    .read_column_i  (read_column_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .cursor_column_o(cursor_column_o),
    .string_ended_o (string_ended_o),
    .glyph_missing_o(glyph_missing_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bit 40 flags a code outside the font; bits 39:32 hold the leftmost column.
  function automatic logic [40:0] glyph_columns(input logic [7:0] code);
    case (code)
      8'h20: return {1'b0, 40'h00_00_00_00_00};
      8'h30: return {1'b0, 40'h3E_51_49_45_3E};
      8'h31: return {1'b0, 40'h00_42_7F_40_00};
      8'h32: return {1'b0, 40'h42_61_51_49_46};
      8'h33: return {1'b0, 40'h21_41_45_4B_31};
      8'h34: return {1'b0, 40'h18_14_12_7F_10};
      8'h35: return {1'b0, 40'h27_45_45_45_39};
      8'h36: return {1'b0, 40'h3C_4A_49_49_30};
      8'h37: return {1'b0, 40'h01_71_09_05_03};
      8'h38: return {1'b0, 40'h36_49_49_49_36};
      8'h39: return {1'b0, 40'h06_49_49_29_1E};
      8'h2E: return {1'b0, 40'h00_60_60_00_00};
      8'h2D: return {1'b0, 40'h08_08_08_08_08};
      8'h3A: return {1'b0, 40'h00_36_36_00_00};
      8'h25: return {1'b0, 40'h23_13_08_64_62};
      8'h43: return {1'b0, 40'h3E_41_41_41_22};
      8'h45: return {1'b0, 40'h7F_49_49_49_41};
      8'h48: return {1'b0, 40'h7F_08_08_08_7F};
      8'h49: return {1'b0, 40'h00_41_7F_41_00};
      8'h4C: return {1'b0, 40'h7F_40_40_40_40};
      8'h4D: return {1'b0, 40'h7F_02_0C_02_7F};
      8'h4F: return {1'b0, 40'h3E_41_41_41_3E};
      8'h50: return {1'b0, 40'h7F_09_09_09_06};
      8'h52: return {1'b0, 40'h7F_09_19_29_46};
      8'h53: return {1'b0, 40'h46_49_49_49_31};
      8'h54: return {1'b0, 40'h01_01_7F_01_01};
      8'h55: return {1'b0, 40'h3F_40_40_40_3F};
      8'h58: return {1'b0, 40'h63_14_08_14_63};
      8'hB0: return {1'b0, 40'h00_07_05_07_00};
      default: return {1'b1, 40'h7F_7F_7F_7F_7F};
    endcase
  endfunction

  // Apply one command to the frame model and return the beat it should produce.
  function automatic raster_beat_t raster_predict(input raster_cmd_t c);
    raster_beat_t r;
    logic [40:0]  glyph;
    logic [7:0]   bits;
    int           gc, sx, rw, sy, px, py, p, x;
    r = '0;
    case (c.op)
      OP_CLEAR: begin
        for (p = 0; p < FRAME_PAGES_DEF; p++)
          for (x = 0; x < FRAME_COLUMNS_DEF; x++) frame_model[p][x] = '0;
      end
      OP_READ: r.frame_byte = frame_model[c.read_page][c.read_column];
      default: begin
        if (c.op == OP_NEW) begin
          str_cursor  = c.start_column;
          str_page    = c.start_page;
          str_scale   = (c.scale == 0) ? 1 : int'(c.scale);
          str_stopped = 1'b0;
        end
        if (!str_stopped) begin
          glyph = glyph_columns(c.code);
          r.glyph_missing = glyph[40];
          for (gc = 0; gc < GLYPH_COLS; gc++) begin
            bits = 8'(glyph[39:0] >> (8 * (4 - gc)));
            for (sx = 0; sx < str_scale; sx++) begin
              px = int'(str_cursor) + gc * str_scale + sx;
              if (px < FRAME_COLUMNS_DEF) begin
                for (rw = 0; rw < GLYPH_ROWS; rw++) begin
                  if (bits[rw]) begin
                    for (sy = 0; sy < str_scale; sy++) begin
                      py = int'(str_page) * PAGE_ROWS + rw * str_scale + sy;
                      if (py < FRAME_PAGES_DEF * PAGE_ROWS)
                        frame_model[py / PAGE_ROWS][px][py % PAGE_ROWS] = 1'b1;
                    end
                  end
                end
              end
            end
          end
          str_cursor = str_cursor + 8'(6 * str_scale);
          if (str_cursor >= FRAME_COLUMNS_DEF) str_stopped = 1'b1;
        end
      end
    endcase
    r.cursor_column = str_cursor;
    r.string_ended  = str_stopped;
    return r;
  endfunction

  function automatic script_row_t row(input op_e op, input logic [7:0] code,
                                      input logic [7:0] col, input logic [3:0] pg,
                                      input logic [3:0] sc, input logic [2:0] rp,
                                      input logic [6:0] rc, input logic typed,
                                      input logic [7:0] fb, input logic [7:0] cur,
                                      input logic ended, input logic missing);
    script_row_t s;
    s.cmd   = '{op, code, col, pg, sc, rp, rc};
    s.typed = typed;
    s.want  = '{fb, cur, ended, missing};
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_quiet > 0) begin
      send_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_code();
    logic [7:0]  code;
    logic [40:0] glyph;
    code = 8'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      glyph = glyph_columns(code);
      while (glyph[40]) begin
        code  = 8'($urandom);
        glyph = glyph_columns(code);
      end
    end
    return code;
  endfunction

  function automatic logic [3:0] pick_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 4'($urandom_range(0, 2));
    if (r < 95) return 4'($urandom_range(3, 6));
    return 4'($urandom_range(7, 15));
  endfunction

  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    c.op           = op_e'($urandom_range(1, 3));
    c.code         = 8'($urandom);
    c.start_column = 8'($urandom);
    c.start_page   = 4'($urandom);
    c.scale        = 4'($urandom);
    c.read_page    = 3'($urandom);
    c.read_column  = 7'($urandom);
    return c;
  endfunction

  task automatic drive_cmd(input raster_cmd_t c, input logic typed,
                           input raster_beat_t typed_beat);
    int           gap;
    raster_beat_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= c.op;
    char_code_i    <= c.code;
    start_column_i <= c.start_column;
    start_page_i   <= c.start_page;
    scale_i        <= c.scale;
    read_page_i    <= c.read_page;
    read_column_i  <= c.read_column;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = raster_predict(c);
    expected_beats.push_back(typed ? typed_beat : predicted);
    accepted_count++;
  endtask

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  task automatic check_beat();
    raster_beat_t got, want;
    got = {frame_byte_o, cursor_column_o, string_ended_o, glyph_missing_o};
    beat_index++;
    if (expected_beats.size() == 0) begin
      note_fault($sformatf("beat %0d arrived with nothing expected", beat_index));
      return;
    end
    want = expected_beats.pop_front();
    if (got.frame_byte !== want.frame_byte || got.cursor_column !== want.cursor_column ||
        got.string_ended !== want.string_ended || got.glyph_missing !== want.glyph_missing)
      note_fault($sformatf({"beat %0d: byte %h/%h cursor %0d/%0d ended %b/%b",
                            " missing %b/%b (expected/actual)"},
                           beat_index, want.frame_byte, got.frame_byte,
                           want.cursor_column, got.cursor_column,
                           want.string_ended, got.string_ended,
                           want.glyph_missing, got.glyph_missing));
  endtask

  // Receiver: runs of free flow, short stalls and the odd long one.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_beat();
    if (sink_span == 0) begin
      sink_pick = $urandom_range(0, 99);
      sink_busy = (sink_pick >= 65);
      if (sink_pick < 65) sink_span = $urandom_range(1, 20);
      else if (sink_pick < 95) sink_span = $urandom_range(1, 4);
      else sink_span = $urandom_range(20, 60);
    end
    sink_span--;
    out_stall_i <= hold_output || sink_busy;
  end

  // Hold the output long enough for the block to back up into its input.
  initial begin
    wait (accepted_count >= 200);
    @(posedge clk_i);
    hold_output <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  initial begin
    #50_000_000;
    $display("scaled_glyph_text_rasterizer verification failed");
    $finish;
  end

  initial begin
    raster_cmd_t c;
    logic [7:0]  origin;
    int          useful, pick, n, k;

    foreach (frame_model[p, x]) frame_model[p][x] = '0;

    //                    op        code   col    pg     sc     rp    rc    T  byte   cur  E  M
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   1, 8'h00, 0,   1, 0));
    // continuing with no string active draws nothing
    script.push_back(row(OP_CONT,  8'h30, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   1, 8'h00, 0,   1, 0));
    // code zero falls back to the solid block
    script.push_back(row(OP_NEW,   8'h00, 8'd0,   4'd0,  4'd1,  3'd0, 7'd0,   1, 8'h00, 6,   0, 1));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   1, 8'h7F, 6,   0, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd5,   1, 8'h00, 6,   0, 0));
    script.push_back(row(OP_CONT,  8'hB0, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   1, 8'h00, 12,  0, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd7,   1, 8'h07, 12,  0, 0));
    // scale zero acts as one; cursor lands on the right edge
    script.push_back(row(OP_NEW,   8'h58, 8'd122, 4'd7,  4'd0,  3'd0, 7'd0,   1, 8'h00, 128, 1, 0));
    script.push_back(row(OP_CONT,  8'h30, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   1, 8'h00, 128, 1, 0));
    // start beyond the store: fully clipped, cursor wraps back below the edge
    script.push_back(row(OP_NEW,   8'hFF, 8'd255, 4'd15, 4'd15, 3'd0, 7'd0,   1, 8'h00, 89,  0, 1));
    script.push_back(row(OP_CONT,  8'h31, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_NEW,   8'h4D, 8'd100, 4'd6,  4'd2,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd7, 7'd100, 0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_CONT,  8'h25, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_CONT,  8'h2E, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd6, 7'd125, 0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_NEW,   8'h20, 8'd0,   4'd0,  4'd3,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    // page below the store draws nothing
    script.push_back(row(OP_NEW,   8'h38, 8'd40,  4'd8,  4'd1,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    // clear keeps the cursor and the string
    script.push_back(row(OP_CLEAR, 8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd6, 7'd101, 1, 8'h00, 46,  0, 0));
    script.push_back(row(OP_NEW,   8'h7F, 8'd127, 4'd0,  4'd1,  3'd0, 7'd0,   1, 8'h00, 133, 1, 1));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd0, 7'd127, 1, 8'h7F, 133, 1, 0));
    script.push_back(row(OP_READ,  8'h00, 8'd0,   4'd0,  4'd0,  3'd7, 7'd127, 1, 8'h00, 133, 1, 0));
    script.push_back(row(OP_NEW,   8'hB0, 8'd0,   4'd0,  4'd4,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));
    script.push_back(row(OP_CONT,  8'h43, 8'd0,   4'd0,  4'd0,  3'd0, 7'd0,   0, 8'h00, 0,   0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) drive_cmd(script[i].cmd, script[i].typed, script[i].want);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed string: start, a few continues, reads around it
        c = random_cmd();
        c.op = OP_NEW;
        c.code = rand_code();
        c.start_column = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 120)) : c.start_column;
        c.start_page = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7)) : c.start_page;
        c.scale = pick_scale();
        origin = c.start_column;
        drive_cmd(c, 1'b0, '0);
        useful++;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          if (str_stopped && $urandom_range(0, 9) != 0) break;
          c = random_cmd();
          c.op = OP_CONT;
          c.code = rand_code();
          if (!str_stopped) useful++;
          drive_cmd(c, 1'b0, '0);
        end
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          c = random_cmd();
          c.op = OP_READ;
          c.read_page = 3'(str_page + 4'($urandom_range(0, 1)));
          c.read_column = 7'(origin + 8'($urandom_range(0, 40)));
          drive_cmd(c, 1'b0, '0);
          useful++;
        end
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          c = random_cmd();
          c.op = OP_READ;
          drive_cmd(c, 1'b0, '0);
          useful++;
        end
      end else if (pick < 88) begin
        c = random_cmd();
        c.op = OP_CLEAR;
        drive_cmd(c, 1'b0, '0);
        useful++;
      end else begin
        c = random_cmd();
        c.scale = pick_scale();
        if (!(c.op == OP_CONT && str_stopped)) useful++;
        drive_cmd(c, 1'b0, '0);
      end
    end

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("scaled_glyph_text_rasterizer verification clean");
    end else begin
      $display("scaled_glyph_text_rasterizer verification failed");
    end
    $finish;
  end

endmodule
